// ===== rtl/ccd_pkg.sv =====
// Shared types, constants and the control store of the coin change dispenser.
`default_nettype none
package ccd_pkg;

    // Fixed field widths of the words on the ports
    localparam int VALUE_W   = 10;
    localparam int CNT_W     = 8;
    localparam int AMT_W     = 20;
    localparam int SLOT_W    = 3;
    localparam int NUM_REGS  = 8;
    localparam int OUT_SLOTS = 8;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Defaults for the top level parameters
    localparam int NUM_DENOMS_DEF  = 8;
    localparam int COUNT_BITS_DEF  = 8;
    localparam int AMOUNT_BITS_DEF = 20;

    // Request codes
    localparam logic OP_CHANGE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_UNDERPAID = 2'd2,
        STATUS_LOADED    = 2'd3
    } ccd_status_t;

    // Input word
    typedef struct packed {
        logic              op;
        logic [AMT_W-1:0]  price_cents;
        logic [AMT_W-1:0]  paid_cents;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  slot_count;
    } ccd_in_t;

    // Result word
    typedef struct packed {
        logic [CNT_W-1:0] given_slot_7;
        logic [CNT_W-1:0] given_slot_6;
        logic [CNT_W-1:0] given_slot_5;
        logic [CNT_W-1:0] given_slot_4;
        logic [CNT_W-1:0] given_slot_3;
        logic [CNT_W-1:0] given_slot_2;
        logic [CNT_W-1:0] given_slot_1;
        logic [CNT_W-1:0] given_slot_0;
        logic [1:0]       status;
        logic [AMT_W-1:0] shortfall_cents;
    } ccd_out_t;

    // Datapath actions of one microstep
    typedef enum logic [3:0] {
        ACT_NOP        = 4'd0,
        ACT_LATCH      = 4'd1,
        ACT_SETUP      = 4'd2,
        ACT_DIV_START  = 4'd3,
        ACT_TAKE       = 4'd4,
        ACT_SUB_NEXT   = 4'd5,
        ACT_COMMIT     = 4'd6,
        ACT_LOAD       = 4'd7,
        ACT_MARK_SHORT = 4'd8,
        ACT_EMIT       = 4'd9
    } ccd_action_t;

    // Jump conditions
    typedef enum logic [3:0] {
        COND_NEVER       = 4'd0,
        COND_ALWAYS      = 4'd1,
        COND_IN_IDLE     = 4'd2,
        COND_IS_LOAD     = 4'd3,
        COND_UNDERPAID   = 4'd4,
        COND_DIV_BUSY    = 4'd5,
        COND_SLOT_MORE   = 4'd6,
        COND_REM_NONZERO = 4'd7,
        COND_OUT_BUSY    = 4'd8
    } ccd_cond_t;

    localparam int STEP_W = 4;

    // Step addresses of the program
    localparam logic [STEP_W-1:0] STEP_FETCH     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SETUP     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIV_START = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TAKE      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SUB_NEXT  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_COMMIT    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SHORT     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd11;
    localparam logic [STEP_W-1:0] STEP_RETURN    = 4'd12;

    // One control word
    typedef struct packed {
        ccd_action_t       action;
        ccd_cond_t         cond;
        logic [STEP_W-1:0] target;
    } ccd_uword_t;

    // Status flags seen by the sequencer
    typedef struct packed {
        logic in_idle;
        logic is_load;
        logic underpaid;
        logic div_busy;
        logic slot_more;
        logic rem_nonzero;
        logic out_busy;
    } ccd_flags_t;

    // Control store: jump to target when the condition holds, else step on
    function automatic ccd_uword_t ccd_rom(input logic [STEP_W-1:0] step);
        ccd_uword_t w;
        w.action = ACT_NOP;
        w.cond   = COND_ALWAYS;
        w.target = STEP_FETCH;
        case (step)
            STEP_FETCH: begin
                w.action = ACT_LATCH;    w.cond = COND_IN_IDLE;     w.target = STEP_FETCH;
            end
            STEP_DISPATCH: begin
                w.action = ACT_NOP;      w.cond = COND_IS_LOAD;     w.target = STEP_LOAD;
            end
            STEP_SETUP: begin
                w.action = ACT_SETUP;    w.cond = COND_UNDERPAID;   w.target = STEP_EMIT;
            end
            STEP_DIV_START: begin
                w.action = ACT_DIV_START; w.cond = COND_NEVER;      w.target = STEP_FETCH;
            end
            STEP_DIV_WAIT: begin
                w.action = ACT_NOP;      w.cond = COND_DIV_BUSY;    w.target = STEP_DIV_WAIT;
            end
            STEP_TAKE: begin
                w.action = ACT_TAKE;     w.cond = COND_NEVER;       w.target = STEP_FETCH;
            end
            STEP_SUB_NEXT: begin
                w.action = ACT_SUB_NEXT; w.cond = COND_SLOT_MORE;   w.target = STEP_DIV_START;
            end
            STEP_CHECK: begin
                w.action = ACT_NOP;      w.cond = COND_REM_NONZERO; w.target = STEP_SHORT;
            end
            STEP_COMMIT: begin
                w.action = ACT_COMMIT;   w.cond = COND_ALWAYS;      w.target = STEP_EMIT;
            end
            STEP_LOAD: begin
                w.action = ACT_LOAD;     w.cond = COND_ALWAYS;      w.target = STEP_EMIT;
            end
            STEP_SHORT: begin
                w.action = ACT_MARK_SHORT; w.cond = COND_NEVER;     w.target = STEP_FETCH;
            end
            STEP_EMIT: begin
                w.action = ACT_EMIT;     w.cond = COND_OUT_BUSY;    w.target = STEP_EMIT;
            end
            STEP_RETURN: begin
                w.action = ACT_NOP;      w.cond = COND_ALWAYS;      w.target = STEP_FETCH;
            end
            default: begin
                w.action = ACT_NOP;      w.cond = COND_ALWAYS;      w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

    // Reset coin values of the configuration registers
    function automatic logic [VALUE_W-1:0] denom_reset(input int idx);
        logic [VALUE_W-1:0] v;
        case (idx)
            0:       v = 10'd1;
            1:       v = 10'd2;
            2:       v = 10'd5;
            3:       v = 10'd10;
            4:       v = 10'd20;
            5:       v = 10'd50;
            6:       v = 10'd100;
            7:       v = 10'd200;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ccd_divider.sv =====
// Restoring divider, one quotient bit per cycle, for amount over coin value.
`default_nettype none
module ccd_divider #(
    parameter int AMOUNT_BITS = ccd_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [AMOUNT_BITS-1:0]      dividend,
    input  wire logic [ccd_pkg::VALUE_W-1:0] divisor,
    output logic                             busy,
    output logic [AMOUNT_BITS-1:0]           quotient
);

    localparam int VW     = ccd_pkg::VALUE_W;
    localparam int CNT_BW = $clog2(AMOUNT_BITS + 1);

    logic [AMOUNT_BITS-1:0] quo_reg, quo_next;
    logic [VW-1:0]          part_reg, part_next;
    logic [CNT_BW-1:0]      count_reg, count_next;
    logic [VW:0]            shifted;
    logic [VW:0]            diff;
    logic                   fits;

    // One shift-and-subtract step
    always_comb begin
        shifted    = {part_reg, quo_reg[AMOUNT_BITS-1]};
        diff       = shifted - {1'b0, divisor};
        fits       = shifted >= {1'b0, divisor};
        quo_next   = quo_reg;
        part_next  = part_reg;
        count_next = count_reg;
        if (start) begin
            quo_next   = dividend;
            part_next  = '0;
            count_next = CNT_BW'(AMOUNT_BITS);
        end else if (count_reg != '0) begin
            quo_next   = {quo_reg[AMOUNT_BITS-2:0], fits};
            part_next  = fits ? diff[VW-1:0] : shifted[VW-1:0];
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
    end

    assign busy     = count_reg != '0;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/ccd_sequencer.sv =====
// Step counter and control store lookup with conditional jumps.
`default_nettype none
module ccd_sequencer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ccd_pkg::ccd_flags_t  flags,
    output ccd_pkg::ccd_uword_t       uword
);

    logic [ccd_pkg::STEP_W-1:0] pc_reg, pc_next;
    logic                       jump;

    assign uword = ccd_pkg::ccd_rom(pc_reg);

    // Condition select
    always_comb begin
        case (uword.cond)
            ccd_pkg::COND_NEVER:       jump = 1'b0;
            ccd_pkg::COND_ALWAYS:      jump = 1'b1;
            ccd_pkg::COND_IN_IDLE:     jump = flags.in_idle;
            ccd_pkg::COND_IS_LOAD:     jump = flags.is_load;
            ccd_pkg::COND_UNDERPAID:   jump = flags.underpaid;
            ccd_pkg::COND_DIV_BUSY:    jump = flags.div_busy;
            ccd_pkg::COND_SLOT_MORE:   jump = flags.slot_more;
            ccd_pkg::COND_REM_NONZERO: jump = flags.rem_nonzero;
            ccd_pkg::COND_OUT_BUSY:    jump = flags.out_busy;
            default:                   jump = 1'b1;
        endcase
        pc_next = jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ccd_pkg::STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/coin_change_dispenser_unit.sv =====
// Top level of the coin change dispenser: APB registers, cash box datapath, sequencer.
// A load word sets the coin count of one slot and then emits its result word.
// A change word hands out paid minus price greedily from the highest slot down; the
// shared bit-serial divider yields one quotient bit per cycle for one slot at a time,
// and each slot adds start, drain, take and subtract steps before the result is emitted.
// A word whose payment falls below the price has the timing of a load word. One word is in
// work at a time; the next is accepted once the result sits in the output register, so a
// stalled result word holds the block. A change word only updates the coin box when the
// whole change is covered. Coin values are written over APB at 4*slot.
`default_nettype none
module coin_change_dispenser_unit #(
    parameter int NUM_DENOMS  = ccd_pkg::NUM_DENOMS_DEF,
    parameter int COUNT_BITS  = ccd_pkg::COUNT_BITS_DEF,
    parameter int AMOUNT_BITS = ccd_pkg::AMOUNT_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input words
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire ccd_pkg::ccd_in_t             s_data,
    // result words
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output ccd_pkg::ccd_out_t                 m_data,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ccd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ccd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ccd_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int VW        = ccd_pkg::VALUE_W;
    localparam int CW        = ccd_pkg::CNT_W;
    localparam int AMT_W     = ccd_pkg::AMT_W;
    localparam int NREG      = ccd_pkg::NUM_REGS;
    localparam int OUT_SLOTS = ccd_pkg::OUT_SLOTS;
    localparam int SLOT_BITS = $clog2(NUM_DENOMS);
    localparam int PROD_BITS = COUNT_BITS + VW;
    localparam int CMP_BITS  = (AMOUNT_BITS > COUNT_BITS) ? AMOUNT_BITS : COUNT_BITS;

    // Configuration registers
    logic [VW-1:0] cfg_reg [NREG];
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = ccd_pkg::PDATA_W'(cfg_reg[paddr[ccd_pkg::PADDR_W-1:2]]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NREG; i++) begin
                cfg_reg[i] <= ccd_pkg::denom_reset(i);
            end
        end else if (cfg_wr) begin
            cfg_reg[paddr[ccd_pkg::PADDR_W-1:2]] <= pwdata[VW-1:0];
        end
    end

    // Coin value of each slot
    logic [VW-1:0] denom_val [NUM_DENOMS];
    for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_val
        if (i < NREG) begin : g_cfg
            assign denom_val[i] = cfg_reg[i];
        end else begin : g_zero
            assign denom_val[i] = '0;
        end
    end

    // Sequencer
    ccd_pkg::ccd_uword_t uword;
    ccd_pkg::ccd_flags_t flags;

    ccd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    // Datapath state
    ccd_pkg::ccd_in_t       in_reg;
    logic [AMOUNT_BITS-1:0] rem_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    ccd_pkg::ccd_status_t   status_reg;
    logic [COUNT_BITS-1:0]  inv_reg  [NUM_DENOMS];
    logic [COUNT_BITS-1:0]  tent_reg [NUM_DENOMS];
    logic [PROD_BITS-1:0]   prod_reg;
    ccd_pkg::ccd_out_t      out_reg;
    logic                   m_valid_reg;

    logic                   div_busy;
    logic [AMOUNT_BITS-1:0] quotient;
    logic [VW-1:0]          cur_val;
    logic [COUNT_BITS-1:0]  cur_inv;
    logic [COUNT_BITS-1:0]  take_w;
    logic                   out_busy;
    logic                   do_emit;
    logic [CW-1:0]          given8 [OUT_SLOTS];
    logic [AMT_W-1:0]       price_diff;

    assign cur_val    = denom_val[slot_reg];
    assign cur_inv    = inv_reg[slot_reg];
    assign out_busy   = m_valid_reg & ~m_ready;
    assign do_emit    = (uword.action == ccd_pkg::ACT_EMIT) && !out_busy;
    assign s_ready    = uword.action == ccd_pkg::ACT_LATCH;
    assign price_diff = in_reg.paid_cents - in_reg.price_cents;

    // Coins taken from the current slot: quotient clamped to coins on hand, none for a zero-valued slot
    always_comb begin
        if (cur_val == '0) begin
            take_w = '0;
        end else if (CMP_BITS'(quotient) > CMP_BITS'(cur_inv)) begin
            take_w = cur_inv;
        end else begin
            take_w = COUNT_BITS'(quotient);
        end
    end

    ccd_divider #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (uword.action == ccd_pkg::ACT_DIV_START),
        .dividend (rem_reg),
        .divisor  (cur_val),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Flags for the sequencer
    always_comb begin
        flags.in_idle     = ~s_valid;
        flags.is_load     = in_reg.op == ccd_pkg::OP_LOAD;
        flags.underpaid   = in_reg.paid_cents < in_reg.price_cents;
        flags.div_busy    = div_busy;
        flags.slot_more   = slot_reg != '0;
        flags.rem_nonzero = rem_reg != '0;
        flags.out_busy    = out_busy;
    end

    // Word latch, amount, slot pointer, status and product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg    <= '0;
            slot_reg   <= '0;
            status_reg <= ccd_pkg::STATUS_DONE;
        end else begin
            case (uword.action)
                ccd_pkg::ACT_SETUP: begin
                    slot_reg <= SLOT_BITS'(NUM_DENOMS - 1);
                    if (flags.underpaid) begin
                        rem_reg    <= '0;
                        status_reg <= ccd_pkg::STATUS_UNDERPAID;
                    end else begin
                        rem_reg    <= AMOUNT_BITS'(price_diff);
                        status_reg <= ccd_pkg::STATUS_DONE;
                    end
                end
                ccd_pkg::ACT_SUB_NEXT: begin
                    rem_reg  <= rem_reg - AMOUNT_BITS'(prod_reg);
                    slot_reg <= slot_reg - 1'b1;
                end
                ccd_pkg::ACT_LOAD:       status_reg <= ccd_pkg::STATUS_LOADED;
                ccd_pkg::ACT_MARK_SHORT: status_reg <= ccd_pkg::STATUS_SHORT;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (uword.action == ccd_pkg::ACT_TAKE) begin
            prod_reg           <= PROD_BITS'(take_w) * PROD_BITS'(cur_val);
            tent_reg[slot_reg] <= take_w;
        end
    end

    // Coin box: load one slot, or commit a covered change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
                inv_reg[i] <= '0;
            end
        end else if (uword.action == ccd_pkg::ACT_LOAD) begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
                if (int'(in_reg.slot_index) == i) begin
                    inv_reg[i] <= COUNT_BITS'(in_reg.slot_count);
                end
            end
        end else if (uword.action == ccd_pkg::ACT_COMMIT) begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
                inv_reg[i] <= inv_reg[i] - tent_reg[i];
            end
        end
    end

    // Per-slot coin counts for the result word
    for (genvar k = 0; k < OUT_SLOTS; k++) begin : g_given
        if (k < NUM_DENOMS) begin : g_slot
            assign given8[k] = (status_reg == ccd_pkg::STATUS_DONE) ? CW'(tent_reg[k]) : '0;
        end else begin : g_none
            assign given8[k] = '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            out_reg.given_slot_7    <= given8[7];
            out_reg.given_slot_6    <= given8[6];
            out_reg.given_slot_5    <= given8[5];
            out_reg.given_slot_4    <= given8[4];
            out_reg.given_slot_3    <= given8[3];
            out_reg.given_slot_2    <= given8[2];
            out_reg.given_slot_1    <= given8[1];
            out_reg.given_slot_0    <= given8[0];
            out_reg.status          <= status_reg;
            out_reg.shortfall_cents <= (status_reg == ccd_pkg::STATUS_SHORT) ?
                                       AMT_W'(rem_reg) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // A result word only appears from the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(uword.action == ccd_pkg::ACT_EMIT))
        else $error("result word raised outside the emit step");

    // The divider is idle whenever a new division is started
    assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.action == ccd_pkg::ACT_DIV_START) |-> !div_busy)
        else $error("division started while divider busy");

    // Never plan to hand out more coins than the slot holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.action == ccd_pkg::ACT_TAKE) |-> (take_w <= cur_inv))
        else $error("coins taken exceed coins on hand");
`endif

endmodule
`default_nettype wire
